/* sv/rrps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrps_pkg
// Types and constants shared by the round-robin scheduler modules.
// ----------------------------------------------------------------------------
package rrps_pkg;

   localparam int VAL_W  = 16;
   localparam int TIME_W = 21;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // request modes
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_RUN  = 1'b1;

   typedef enum logic [1:0] {
      ST_LOADED = 2'd0,
      ST_RUN    = 2'd1,
      ST_FULL   = 2'd2,
      ST_IDLE   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_LOAD,
      S_SCAN1,
      S_JUMP,
      S_SCAN2,
      S_POP_RD,
      S_POP,
      S_EXEC_RD,
      S_EXEC,
      S_SCAN3,
      S_RETIRE,
      S_REPORT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic       capture;
      logic       load;
      logic       scan_clear;
      logic       scan_step;
      logic       scan_skip;
      logic       jump;
      logic       pop_rd;
      logic       pop;
      logic       entry_rd;
      logic       exec;
      logic       retire;
      logic       report;
      status_type code;
   } ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic mode;
      logic table_full;
      logic nothing_left;
      logic scan_done;
      logic fifo_empty;
      logic out_free;
   } sts_type;

endpackage

/* sv/rrps_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrps_ctrl
// Sequencer for load and run requests: drives the datapath through the
// arrival scans, dispatch, execution and result report.
// ----------------------------------------------------------------------------
module rrps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rrps_pkg::sts_type sts,
   output rrps_pkg::ctl_type ctl
);

   rrps_pkg::state_type  state_ff, state_in;
   rrps_pkg::status_type code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrps_pkg::S_IDLE;
         code_ff  <= rrps_pkg::ST_LOADED;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      case (state_ff)
         rrps_pkg::S_IDLE: begin
            if (req_valid) state_in = rrps_pkg::S_DECODE;
         end
         rrps_pkg::S_DECODE: begin
            if (sts.mode == rrps_pkg::MODE_LOAD) begin
               if (sts.table_full) begin
                  state_in = rrps_pkg::S_REPORT;
                  code_in  = rrps_pkg::ST_FULL;
               end else begin
                  state_in = rrps_pkg::S_LOAD;
               end
            end else if (sts.nothing_left) begin
               state_in = rrps_pkg::S_REPORT;
               code_in  = rrps_pkg::ST_IDLE;
            end else begin
               state_in = rrps_pkg::S_SCAN1;
            end
         end
         rrps_pkg::S_LOAD: begin
            state_in = rrps_pkg::S_REPORT;
            code_in  = rrps_pkg::ST_LOADED;
         end
         rrps_pkg::S_SCAN1: begin
            if (sts.scan_done) begin
               state_in = sts.fifo_empty ? rrps_pkg::S_JUMP : rrps_pkg::S_POP_RD;
            end
         end
         rrps_pkg::S_JUMP: state_in = rrps_pkg::S_SCAN2;
         rrps_pkg::S_SCAN2: begin
            if (sts.scan_done) begin
               if (sts.fifo_empty) begin
                  state_in = rrps_pkg::S_REPORT;
                  code_in  = rrps_pkg::ST_IDLE;
               end else begin
                  state_in = rrps_pkg::S_POP_RD;
               end
            end
         end
         rrps_pkg::S_POP_RD:  state_in = rrps_pkg::S_POP;
         rrps_pkg::S_POP:     state_in = rrps_pkg::S_EXEC_RD;
         rrps_pkg::S_EXEC_RD: state_in = rrps_pkg::S_EXEC;
         rrps_pkg::S_EXEC:    state_in = rrps_pkg::S_SCAN3;
         rrps_pkg::S_SCAN3: begin
            if (sts.scan_done) state_in = rrps_pkg::S_RETIRE;
         end
         rrps_pkg::S_RETIRE: begin
            state_in = rrps_pkg::S_REPORT;
            code_in  = rrps_pkg::ST_RUN;
         end
         rrps_pkg::S_REPORT: begin
            if (sts.out_free) state_in = rrps_pkg::S_IDLE;
         end
         default: state_in = rrps_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl       = '0;
      ctl.code  = code_ff;
      req_ready = 1'b0;
      case (state_ff)
         rrps_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            ctl.capture = req_valid;
         end
         rrps_pkg::S_DECODE: begin
            ctl.scan_clear = 1'b1;
         end
         rrps_pkg::S_LOAD:    ctl.load = 1'b1;
         rrps_pkg::S_SCAN1:   ctl.scan_step = 1'b1;
         rrps_pkg::S_JUMP: begin
            ctl.jump       = 1'b1;
            ctl.scan_clear = 1'b1;
         end
         rrps_pkg::S_SCAN2:   ctl.scan_step = 1'b1;
         rrps_pkg::S_POP_RD:  ctl.pop_rd = 1'b1;
         rrps_pkg::S_POP:     ctl.pop = 1'b1;
         rrps_pkg::S_EXEC_RD: ctl.entry_rd = 1'b1;
         rrps_pkg::S_EXEC: begin
            ctl.exec       = 1'b1;
            ctl.scan_clear = 1'b1;
         end
         rrps_pkg::S_SCAN3: begin
            ctl.scan_step = 1'b1;
            ctl.scan_skip = 1'b1;
         end
         rrps_pkg::S_RETIRE:  ctl.retire = 1'b1;
         rrps_pkg::S_REPORT:  ctl.report = sts.out_free;
         default: ctl = '0;
      endcase
   end

endmodule

/* sv/rrps_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrps_dpath
// Process table, ready queue, time keeping and result register of the
// round-robin scheduler. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module rrps_dpath #(
   parameter int MAX_PROCS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rrps_pkg::ctl_type              ctl,
   output rrps_pkg::sts_type              sts,
   input  logic [rrps_pkg::VAL_W-1:0]     quantum,
   input  logic                           req_mode,
   input  logic [rrps_pkg::VAL_W-1:0]     req_burst_time,
   input  logic [rrps_pkg::VAL_W-1:0]     req_arrival_time,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [3:0]                     rsp_process_index,
   output logic [rrps_pkg::TIME_W-1:0]    rsp_slice_end_time,
   output logic                           rsp_finished,
   output logic [rrps_pkg::TIME_W-1:0]    rsp_waiting_time,
   output logic [rrps_pkg::TIME_W-1:0]    rsp_turnaround_time,
   output logic                           rsp_all_done
);

   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam int VW    = rrps_pkg::VAL_W;
   localparam int TW    = rrps_pkg::TIME_W;
   localparam int ENT_W = 3 * VW;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_PROCS - 1);

   // table entry: burst, arrival, remaining
   logic [ENT_W-1:0] proc_mem [MAX_PROCS];
   logic [IDX_W-1:0] fifo_mem [MAX_PROCS];

   // control state
   logic [TW-1:0]        time_ff, time_in;
   logic [CNT_W-1:0]     pcount_ff, pcount_in;
   logic [CNT_W-1:0]     done_ff, done_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]     fcount_ff, fcount_in;
   logic [MAX_PROCS-1:0] queued_ff, queued_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic                 rdv_ff, rdv_in;
   logic                 best_vld_ff, best_vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload
   logic                 mode_ff;
   logic [VW-1:0]        bt_ff;
   logic [VW-1:0]        at_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [VW-1:0]        best_ff, best_in;
   logic [IDX_W-1:0]     pidx_ff, pidx_in;
   logic [IDX_W-1:0]     res_idx_ff, res_idx_in;
   logic [VW-1:0]        cur_bt_ff, cur_at_ff, cur_rem_ff;
   logic                 fin_ff, fin_in;
   logic [TW-1:0]        wt_ff, wt_in;
   logic [TW-1:0]        tat_ff, tat_in;
   logic [ENT_W-1:0]     ent_q_ff;
   logic [IDX_W-1:0]     fifo_q_ff;
   logic [1:0]           o_status_ff;
   logic [IDX_W-1:0]     o_idx_ff;
   logic [TW-1:0]        o_time_ff;
   logic                 o_fin_ff;
   logic [TW-1:0]        o_wt_ff;
   logic [TW-1:0]        o_tat_ff;
   logic                 o_all_ff;

   // datapath nets
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENT_W-1:0]   wr_data;
   logic               push;
   logic [IDX_W-1:0]   push_idx;
   logic [VW-1:0]      e_bt, e_at, e_rem;
   logic               scan_more;
   logic               scan_hit;
   logic [VW-1:0]      q_eff;
   logic [VW-1:0]      ex;
   logic [TW:0]        t_sum;
   logic [VW:0]        ba_sum;
   logic               ge;
   logic [IDX_W+3:0]   idx_ext;

   assign e_bt  = ent_q_ff[3*VW-1:2*VW];
   assign e_at  = ent_q_ff[2*VW-1:VW];
   assign e_rem = ent_q_ff[VW-1:0];

   assign scan_more = (scan_ff != pcount_ff);
   assign scan_hit  = rdv_ff && !(ctl.scan_skip && (rd_idx_ff == pidx_ff))
                      && ({{(TW-VW){1'b0}}, e_at} <= time_ff)
                      && (e_rem != '0) && !queued_ff[rd_idx_ff]
                      && (fcount_ff != CNT_MAX);

   assign q_eff  = (quantum == '0) ? VW'(1) : quantum;
   assign ex     = (e_rem < q_eff) ? e_rem : q_eff;
   assign t_sum  = {1'b0, time_ff} + {{(TW+1-VW){1'b0}}, ex};
   assign ba_sum = {1'b0, cur_bt_ff} + {1'b0, cur_at_ff};
   assign ge     = (time_ff >= {{(TW-VW-1){1'b0}}, ba_sum});

   always_comb begin
      time_in      = time_ff;
      pcount_in    = pcount_ff;
      done_in      = done_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fcount_in    = fcount_ff;
      queued_in    = queued_ff;
      scan_in      = scan_ff;
      rdv_in       = 1'b0;
      best_vld_in  = best_vld_ff;
      best_in      = best_ff;
      pidx_in      = pidx_ff;
      res_idx_in   = res_idx_ff;
      fin_in       = fin_ff;
      wt_in        = wt_ff;
      tat_in       = tat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_en        = 1'b0;
      rd_addr      = scan_ff[IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = pidx_ff;
      wr_data      = {cur_bt_ff, cur_at_ff, cur_rem_ff};
      push         = 1'b0;
      push_idx     = rd_idx_ff;

      if (ctl.capture) begin
         fin_in = 1'b0;
         wt_in  = '0;
         tat_in = '0;
      end

      if (ctl.load) begin
         wr_en      = 1'b1;
         wr_addr    = pcount_ff[IDX_W-1:0];
         wr_data    = {bt_ff, at_ff, bt_ff};
         queued_in[pcount_ff[IDX_W-1:0]] = 1'b0;
         res_idx_in = pcount_ff[IDX_W-1:0];
         pcount_in  = pcount_ff + CNT_W'(1);
         if (bt_ff == '0) done_in = done_ff + CNT_W'(1);
      end

      if (ctl.scan_clear) begin
         scan_in     = '0;
         best_vld_in = 1'b0;
      end

      if (ctl.scan_step) begin
         // issue the next table read, evaluate the one returned
         if (scan_more) begin
            rd_en   = 1'b1;
            rdv_in  = 1'b1;
            scan_in = scan_ff + CNT_W'(1);
         end
         if (rdv_ff && (e_rem != '0) && (!best_vld_ff || (e_at < best_ff))) begin
            best_vld_in = 1'b1;
            best_in     = e_at;
         end
         if (scan_hit) begin
            push     = 1'b1;
            push_idx = rd_idx_ff;
         end
      end

      if (ctl.jump && best_vld_ff && ({{(TW-VW){1'b0}}, best_ff} > time_ff)) begin
         time_in = {{(TW-VW){1'b0}}, best_ff};
      end

      if (ctl.pop) begin
         pidx_in    = fifo_q_ff;
         res_idx_in = fifo_q_ff;
         queued_in[fifo_q_ff] = 1'b0;
         head_in    = (head_ff == IDX_LAST) ? '0 : head_ff + IDX_W'(1);
         fcount_in  = fcount_ff - CNT_W'(1);
      end

      if (ctl.entry_rd) begin
         rd_en   = 1'b1;
         rd_addr = pidx_ff;
      end

      if (ctl.exec) begin
         time_in = t_sum[TW] ? rrps_pkg::TIME_MAX : t_sum[TW-1:0];
         wr_en   = 1'b1;
         wr_addr = pidx_ff;
         wr_data = {e_bt, e_at, e_rem - ex};
      end

      if (ctl.retire) begin
         if (cur_rem_ff != '0) begin
            if (fcount_ff != CNT_MAX) begin
               push     = 1'b1;
               push_idx = pidx_ff;
            end
         end else begin
            fin_in  = 1'b1;
            done_in = done_ff + CNT_W'(1);
            wt_in   = ge ? time_ff - {{(TW-VW-1){1'b0}}, ba_sum} : '0;
            tat_in  = ge ? time_ff - {{(TW-VW){1'b0}}, cur_at_ff}
                         : {{(TW-VW){1'b0}}, cur_bt_ff};
         end
      end

      if (push) begin
         queued_in[push_idx] = 1'b1;
         tail_in   = (tail_ff == IDX_LAST) ? '0 : tail_ff + IDX_W'(1);
         fcount_in = fcount_ff + CNT_W'(1);
      end

      if (ctl.report) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff      <= '0;
         pcount_ff    <= '0;
         done_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fcount_ff    <= '0;
         queued_ff    <= '0;
         scan_ff      <= '0;
         rdv_ff       <= 1'b0;
         best_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         time_ff      <= time_in;
         pcount_ff    <= pcount_in;
         done_ff      <= done_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fcount_ff    <= fcount_in;
         queued_ff    <= queued_in;
         scan_ff      <= scan_in;
         rdv_ff       <= rdv_in;
         best_vld_ff  <= best_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         mode_ff <= req_mode;
         bt_ff   <= req_burst_time;
         at_ff   <= req_arrival_time;
      end
      if (ctl.exec) begin
         cur_bt_ff  <= e_bt;
         cur_at_ff  <= e_at;
         cur_rem_ff <= e_rem - ex;
      end
      rd_idx_ff  <= scan_ff[IDX_W-1:0];
      best_ff    <= best_in;
      pidx_ff    <= pidx_in;
      res_idx_ff <= res_idx_in;
      fin_ff     <= fin_in;
      wt_ff      <= wt_in;
      tat_ff     <= tat_in;
   end

   // process table
   always_ff @(posedge clock) begin
      if (wr_en) proc_mem[wr_addr] <= wr_data;
      if (rd_en) ent_q_ff <= proc_mem[rd_addr];
   end

   // ready queue
   always_ff @(posedge clock) begin
      if (push) fifo_mem[tail_ff] <= push_idx;
      if (ctl.pop_rd) fifo_q_ff <= fifo_mem[head_ff];
   end

   // result register
   always_ff @(posedge clock) begin
      if (ctl.report) begin
         o_status_ff <= ctl.code;
         o_idx_ff    <= ((ctl.code == rrps_pkg::ST_LOADED) || (ctl.code == rrps_pkg::ST_RUN))
                        ? res_idx_ff : '0;
         o_time_ff   <= time_ff;
         o_fin_ff    <= fin_ff;
         o_wt_ff     <= wt_ff;
         o_tat_ff    <= tat_ff;
         o_all_ff    <= (done_ff >= pcount_ff);
      end
   end

   assign idx_ext = {4'b0000, o_idx_ff};

   assign sts.mode         = mode_ff;
   assign sts.table_full   = (pcount_ff == CNT_MAX);
   assign sts.nothing_left = (done_ff >= pcount_ff);
   assign sts.scan_done    = !scan_more && !rdv_ff;
   assign sts.fifo_empty   = (fcount_ff == '0);
   assign sts.out_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = o_status_ff;
   assign rsp_process_index   = idx_ext[3:0];
   assign rsp_slice_end_time  = o_time_ff;
   assign rsp_finished        = o_fin_ff;
   assign rsp_waiting_time    = o_wt_ff;
   assign rsp_turnaround_time = o_tat_ff;
   assign rsp_all_done        = o_all_ff;

endmodule

/* sv/round_robin_process_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_process_scheduler
// Round-robin scheduler over a table of processes: load requests append a
// process, run requests dispatch one time slice and report completion.
//
//   channel | ports   | direction | content
//   --------+---------+-----------+------------------------------------------
//   request | req_*   | in        | mode, burst_time, arrival_time
//   result  | rsp_*   | out       | status, index, times, finished, all_done
//   config  | csr_*   | in/out    | APB-style, quantum at byte address 0
//
// A load is rejected when the table is full. A run's duration grows with
// the number of loaded processes through the arrival scans, which read one
// table entry per memory cycle; a time jump adds a further scan.
// Reset is synchronous and clears the table count, queue and time; no
// clearing pass is needed. A new request is taken while a result waits;
// the following result holds until the waiting one is taken.
// ----------------------------------------------------------------------------
module round_robin_process_scheduler #(
   parameter int MAX_PROCS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_mode,
   input  logic [rrps_pkg::VAL_W-1:0]  req_burst_time,
   input  logic [rrps_pkg::VAL_W-1:0]  req_arrival_time,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [3:0]                  rsp_process_index,
   output logic [rrps_pkg::TIME_W-1:0] rsp_slice_end_time,
   output logic                        rsp_finished,
   output logic [rrps_pkg::TIME_W-1:0] rsp_waiting_time,
   output logic [rrps_pkg::TIME_W-1:0] rsp_turnaround_time,
   output logic                        rsp_all_done,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   logic [rrps_pkg::VAL_W-1:0] quantum_ff, quantum_in;
   logic                       csr_hit;
   rrps_pkg::ctl_type          ctl;
   rrps_pkg::sts_type          sts;

   // only the first word holds a register
   assign csr_hit    = (csr_paddr[2] == 1'b0);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? {{(32 - rrps_pkg::VAL_W){1'b0}}, quantum_ff} : '0;

   always_comb begin
      quantum_in = quantum_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         quantum_in = csr_pwdata[rrps_pkg::VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= rrps_pkg::VAL_W'(1);
      end else begin
         quantum_ff <= quantum_in;
      end
   end

   rrps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   rrps_dpath #(
      .MAX_PROCS (MAX_PROCS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .sts                 (sts),
      .quantum             (quantum_ff),
      .req_mode            (req_mode),
      .req_burst_time      (req_burst_time),
      .req_arrival_time    (req_arrival_time),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_process_index   (rsp_process_index),
      .rsp_slice_end_time  (rsp_slice_end_time),
      .rsp_finished        (rsp_finished),
      .rsp_waiting_time    (rsp_waiting_time),
      .rsp_turnaround_time (rsp_turnaround_time),
      .rsp_all_done        (rsp_all_done)
   );

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the round-robin process scheduler. Load and run
// requests go in over the request channel. A scheduling model inside the
// bench tracks the process table, the ready queue and the clock of the
// schedule, and it predicts every result. Each result is compared field by
// field. The quantum is rewritten between phases and read back. Directed
// cases cover the empty table, zero burst, zero quantum, time jumps, the
// longest burst and a full table. Random phases run before the last two,
// with idle cycles on both sides and one long stall of the result side.
// ----------------------------------------------------------------------------
module tb;

   localparam int VW              = rrps_pkg::VAL_W;
   localparam int TW              = rrps_pkg::TIME_W;
   localparam int PROC_SLOTS      = 16;
   localparam int RESERVED_SLOTS  = 13;   // leave room for the closing tests
   localparam int RANDOM_ITEMS    = 880;
   localparam int RSP_HOLD_CYCLES = 500;
   localparam int SETTLE_CYCLES   = 4 * (PROC_SLOTS + 2) + 20;
   localparam logic [2:0] QUANTUM_ADDR = 3'd0;

   typedef struct packed {
      rrps_pkg::status_type status;
      logic [3:0]           index;
      logic [TW-1:0]        end_time;
      logic                 finished;
      logic [TW-1:0]        waiting;
      logic [TW-1:0]        turnaround;
      logic                 all_done;
   } slice_report_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_mode = rrps_pkg::MODE_LOAD;
   logic [VW-1:0]       req_burst_time = '0;
   logic [VW-1:0]       req_arrival_time = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [1:0]          rsp_status;
   logic [3:0]          rsp_process_index;
   logic [TW-1:0]       rsp_slice_end_time;
   logic                rsp_finished;
   logic [TW-1:0]       rsp_waiting_time;
   logic [TW-1:0]       rsp_turnaround_time;
   logic                rsp_all_done;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [2:0]          csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   // scheduling model state
   logic [VW-1:0]       burst_tbl   [PROC_SLOTS];
   logic [VW-1:0]       arrival_tbl [PROC_SLOTS];
   logic [VW-1:0]       remain_tbl  [PROC_SLOTS];
   logic                queued      [PROC_SLOTS];
   logic [3:0]          ready_ring  [PROC_SLOTS];
   logic [3:0]          ring_head;
   int unsigned         ring_count;
   logic [TW-1:0]       now_time;
   int unsigned         proc_total;
   int unsigned         done_total;
   logic [VW-1:0]       quantum_reg;

   slice_report_type    expected_reports[$];
   int                  mismatches = 0;
   int                  results_seen = 0;
   bit                  calm = 1'b0;
   int                  hold_requests = 0;
   int                  hold_served = 0;
   int                  hold_left = 0;

   round_robin_process_scheduler #(.MAX_PROCS(PROC_SLOTS)) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_burst_time      (req_burst_time),
      .req_arrival_time    (req_arrival_time),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_process_index   (rsp_process_index),
      .rsp_slice_end_time  (rsp_slice_end_time),
      .rsp_finished        (rsp_finished),
      .rsp_waiting_time    (rsp_waiting_time),
      .rsp_turnaround_time (rsp_turnaround_time),
      .rsp_all_done        (rsp_all_done),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [VW-1:0] rand_word();
      logic [31:0] r;
      r = $urandom;
      return r[VW-1:0];
   endfunction

   // ------------------------------------------------------------------------
   // scheduling model
   // ------------------------------------------------------------------------
   task automatic clear_schedule();
      for (int i = 0; i < PROC_SLOTS; i++) begin
         burst_tbl[i]   = '0;
         arrival_tbl[i] = '0;
         remain_tbl[i]  = '0;
         queued[i]      = 1'b0;
         ready_ring[i]  = '0;
      end
      ring_head   = '0;
      ring_count  = 0;
      now_time    = '0;
      proc_total  = 0;
      done_total  = 0;
      quantum_reg = 16'd1;
   endtask

   function automatic void enqueue_proc(int unsigned p);
      if (ring_count >= PROC_SLOTS || p >= PROC_SLOTS)
         return;
      ready_ring[(ring_head + ring_count) % PROC_SLOTS] = p[3:0];
      ring_count++;
      queued[p] = 1'b1;
   endfunction

   function automatic int unsigned dequeue_proc();
      int unsigned p;
      p = ready_ring[ring_head];
      ring_head = ring_head + 4'd1;
      ring_count--;
      queued[p] = 1'b0;
      return p;
   endfunction

   // queue every arrived, unfinished, unqueued process except skip
   function automatic void scan_for_arrivals(int unsigned skip);
      for (int unsigned i = 0; i < proc_total && i < PROC_SLOTS; i++) begin
         if (i != skip && arrival_tbl[i] <= now_time && remain_tbl[i] > 0 && !queued[i])
            enqueue_proc(i);
      end
   endfunction

   function automatic slice_report_type schedule_step(logic mode, logic [VW-1:0] bt,
                                                      logic [VW-1:0] at);
      slice_report_type r;
      int unsigned      q, ex, t, best, pick, tat;
      longint           w;
      r = '0;
      if (mode == rrps_pkg::MODE_LOAD) begin
         if (proc_total >= PROC_SLOTS) begin
            r.status = rrps_pkg::ST_FULL;
         end else begin
            r.index = proc_total[3:0];
            burst_tbl[proc_total]   = bt;
            arrival_tbl[proc_total] = at;
            remain_tbl[proc_total]  = bt;
            queued[proc_total]      = 1'b0;
            proc_total++;
            if (bt == 0)
               done_total++;
            r.status = rrps_pkg::ST_LOADED;
         end
      end else if (done_total >= proc_total) begin
         r.status = rrps_pkg::ST_IDLE;
      end else begin
         q = (quantum_reg == 0) ? 1 : quantum_reg;
         scan_for_arrivals(PROC_SLOTS);
         if (ring_count == 0) begin
            // jump ahead to the earliest pending arrival
            best = 32'hFFFF_FFFF;
            for (int unsigned i = 0; i < proc_total && i < PROC_SLOTS; i++)
               if (remain_tbl[i] > 0 && arrival_tbl[i] < best)
                  best = arrival_tbl[i];
            if (best != 32'hFFFF_FFFF && best > now_time)
               now_time = best[TW-1:0];
            scan_for_arrivals(PROC_SLOTS);
         end
         if (ring_count == 0) begin
            r.status = rrps_pkg::ST_IDLE;
         end else begin
            pick = dequeue_proc();
            ex = (remain_tbl[pick] < q) ? remain_tbl[pick] : q;
            t = now_time + ex;
            now_time = (t > rrps_pkg::TIME_MAX) ? rrps_pkg::TIME_MAX : t[TW-1:0];
            remain_tbl[pick] = remain_tbl[pick] - ex[VW-1:0];
            scan_for_arrivals(pick);
            if (remain_tbl[pick] > 0) begin
               enqueue_proc(pick);
            end else begin
               w = longint'(now_time) - longint'(burst_tbl[pick]) - longint'(arrival_tbl[pick]);
               if (w < 0)
                  w = 0;
               done_total++;
               tat = int'(w) + burst_tbl[pick];
               if (tat > rrps_pkg::TIME_MAX)
                  tat = rrps_pkg::TIME_MAX;
               r.finished   = 1'b1;
               r.waiting    = w[TW-1:0];
               r.turnaround = tat[TW-1:0];
            end
            r.status = rrps_pkg::ST_RUN;
            r.index  = pick[3:0];
         end
      end
      r.end_time = now_time;
      r.all_done = (done_total >= proc_total);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      if (mismatches < 100)
         $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      slice_report_type want;
      string            bad;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            report_mismatch($sformatf("result %0d with no request outstanding", results_seen));
         end else begin
            want = expected_reports.pop_front();
            bad = "";
            if (rsp_status !== want.status)              bad = {bad, " status"};
            if (rsp_process_index !== want.index)        bad = {bad, " index"};
            if (rsp_slice_end_time !== want.end_time)    bad = {bad, " end_time"};
            if (rsp_finished !== want.finished)          bad = {bad, " finished"};
            if (rsp_waiting_time !== want.waiting)       bad = {bad, " waiting"};
            if (rsp_turnaround_time !== want.turnaround) bad = {bad, " turnaround"};
            if (rsp_all_done !== want.all_done)          bad = {bad, " all_done"};
            if (bad != "")
               report_mismatch($sformatf(
                  "result %0d bad%s: got %0d/%0d/%0d/%0d/%0d/%0d/%0d exp %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                  results_seen, bad, rsp_status, rsp_process_index, rsp_slice_end_time,
                  rsp_finished, rsp_waiting_time, rsp_turnaround_time, rsp_all_done,
                  want.status, want.index, want.end_time, want.finished, want.waiting,
                  want.turnaround, want.all_done));
         end
         results_seen++;
      end
   end

   // result side: random stalls, a long hold on demand
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= RSP_HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 15);
      end
   end

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   task automatic send_request(input logic mode, input logic [VW-1:0] bt,
                               input logic [VW-1:0] at);
      slice_report_type want;
      if (!calm && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 40);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_burst_time   <= bt;
      req_arrival_time <= at;
      do @(posedge clock); while (!req_ready);
      want = schedule_step(mode, bt, at);
      expected_reports.insert(expected_reports.size(), want);
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_reports.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_quantum(input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= QUANTUM_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      quantum_reg = value[VW-1:0];
      // read back
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[VW-1:0] !== value[VW-1:0])
         report_mismatch($sformatf("quantum read back %0h, wrote %0h",
                                   csr_prdata[VW-1:0], value[VW-1:0]));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_empty_table();
      send_request(rrps_pkg::MODE_RUN, 16'hFFFF, 16'hFFFF);
      send_request(rrps_pkg::MODE_RUN, 16'h0000, 16'h0000);
      wait_results_drained();
   endtask

   task automatic test_zero_burst();
      send_request(rrps_pkg::MODE_LOAD, 16'd0, 16'd0);
      send_request(rrps_pkg::MODE_RUN, 16'd0, 16'd0);
      wait_results_drained();
   endtask

   // zero quantum acts as one; the empty queue forces jumps to later arrivals
   task automatic test_time_jump();
      write_quantum(32'd0);
      send_request(rrps_pkg::MODE_LOAD, 16'd3, 16'hFFFF);
      send_request(rrps_pkg::MODE_LOAD, 16'd2, 16'd100);
      repeat (6) send_request(rrps_pkg::MODE_RUN, rand_word(), rand_word());
      wait_results_drained();
   endtask

   task automatic test_random_schedule();
      int            sent, phase, span, roll;
      int unsigned   arr;
      logic [31:0]   q;
      logic [31:0]   r32;
      logic [VW-1:0] bt, at;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         roll = $urandom_range(99);
         if (phase == 0)
            q = 32'd1;
         else if (roll < 65)
            q = $urandom_range(1, 8);
         else if (roll < 90)
            q = $urandom_range(9, 64);
         else
            q = 32'hFFFF;
         q[31:16] = rand_word();
         write_quantum(q);
         calm = (phase == 1);
         if (phase == 2)
            hold_requests++;
         span = $urandom_range(60, 140);
         repeat (span) begin
            if (proc_total < RESERVED_SLOTS &&
                $urandom_range(99) < ((proc_total < 4) ? 40 : 3)) begin
               r32 = ($urandom_range(99) < 92) ? $urandom_range(1, 400) : $urandom;
               bt  = r32[VW-1:0];
               if ($urandom_range(99) < 75) begin
                  arr = now_time + $urandom_range(0, 300);
                  at  = (arr > 32'hFFFF) ? 16'hFFFF : arr[VW-1:0];
               end else begin
                  at = rand_word();
               end
               send_request(rrps_pkg::MODE_LOAD, bt, at);
            end else begin
               send_request(rrps_pkg::MODE_RUN, rand_word(), rand_word());
            end
            sent++;
         end
         wait_results_drained();
         calm = 1'b0;
         phase++;
      end
   endtask

   task automatic test_long_burst();
      int guard;
      write_quantum(32'h0000_FFFF);
      send_request(rrps_pkg::MODE_LOAD, 16'hFFFF, 16'hFFFF);
      guard = 0;
      while (done_total < proc_total && guard < 64) begin
         send_request(rrps_pkg::MODE_RUN, rand_word(), rand_word());
         guard++;
      end
      wait_results_drained();
   endtask

   task automatic test_table_full();
      int guard;
      write_quantum(32'd1);
      while (proc_total < PROC_SLOTS)
         send_request(rrps_pkg::MODE_LOAD, 16'd1, 16'd0);
      send_request(rrps_pkg::MODE_LOAD, 16'h1234, 16'h00FF);
      send_request(rrps_pkg::MODE_LOAD, 16'hFFFF, 16'h0000);
      guard = 0;
      while (done_total < proc_total && guard < 64) begin
         send_request(rrps_pkg::MODE_RUN, rand_word(), rand_word());
         guard++;
      end
      send_request(rrps_pkg::MODE_RUN, rand_word(), rand_word());
      wait_results_drained();
   endtask

   initial begin
      clear_schedule();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_zero_burst();
      test_time_jump();
      test_random_schedule();
      test_long_burst();
      test_table_full();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #15_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
